@@ rtl/assert_macros.svh @@
// Assertion macros shared by the SPI master RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/spi4_pkg.sv @@
// Shared types, constants and helpers for the four-mode SPI master
package spi4_pkg;

  localparam int TICK_W   = 16;  // tick counter width, matches the delay registers
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;
  localparam int BYTE_W   = 8;
  localparam int BIT_CW   = 3;
  localparam logic [BIT_CW-1:0] LAST_BIT = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_SPI_MODE   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_BIT_ORDER  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_HALF_TICKS = 2'd2;
  localparam logic [CFG_AW-1:0] REG_SEL_TICKS  = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SETUP = 3'd1,
    PH_LEAD  = 3'd2,
    PH_TRAIL = 3'd3,
    PH_WAIT  = 3'd4,
    PH_HOLD  = 3'd5
  } phase_t;

  // Live configuration, delays already clamped to at least one tick
  typedef struct packed {
    logic              cpol;
    logic              cpha;
    logic              msb_lead;
    logic [TICK_W-1:0] half_lim;
    logic [TICK_W-1:0] sel_lim;
  } cfg_t;

  // One tick's worth of input
  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_last;
    logic              miso;
  } tick_t;

  // One tick's worth of result
  typedef struct packed {
    logic              sck;
    logic              mosi;
    logic              cs_n;
    logic              ready_res;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
  } result_t;

  // Bit position on the wire for a given bit number
  function automatic logic [BIT_CW-1:0] bit_idx(input logic msb, input logic [BIT_CW-1:0] bc);
    bit_idx = msb ? (LAST_BIT - bc) : bc;
  endfunction

endpackage

@@ rtl/spi_master_four_mode.sv @@
// Top level of the four-mode SPI master: beat registers around the serial engine
// A beat taken into the input register steps the engine into the output register.
// Throughput: one input beat per cycle, each one tick of the serial engine, unless
// out_tready stalls. The rate is set by the single-pass step between the two registers.
// Synchronous active-low reset empties both beat registers, deselects the slave,
// and loads mode 0, MSB first and one-tick delays.
module spi_master_four_mode
  import spi4_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input beats
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [7:0] tx_byte, [8] miso, [15:9] zero
  input  logic              in_tuser,   // [0] tx_valid
  input  logic              in_tlast,   // tx_last
  // result beats
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [0] sck, [1] mosi, [2] cs_n, [3] ready_res,
                                        // [11:4] rx_byte, [15:12] zero
  output logic              out_tuser,  // [0] rx_valid
  // configuration writes
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  `include "assert_macros.svh"

  cfg_t    cfg;
  tick_t   tick_r;
  logic    in_valid_r;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    adv;

  spi4_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Output register is free or drains this cycle
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || adv;

  // Input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      tick_r.tx_valid <= in_tuser;
      tick_r.tx_byte  <= in_tdata[7:0];
      tick_r.tx_last  <= in_tlast;
      tick_r.miso     <= in_tdata[8];
    end
  end

  spi4_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_valid_r && adv),
    .tick  (tick_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && adv) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.rx_valid;
  assign out_tdata  = {4'd0, res_r.rx_byte, res_r.ready_res, res_r.cs_n, res_r.mosi, res_r.sck};

  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_r && !adv, in_valid_r,
               "stalled input beat dropped before the engine took it")

endmodule

@@ rtl/spi4_cfg.sv @@
// Configuration register bank of the SPI master
module spi4_cfg
  import spi4_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t              cfg
);

  logic [1:0]        mode_r;
  logic              msb_r;
  logic [TICK_W-1:0] half_r;
  logic [TICK_W-1:0] sel_r;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 2'd0;
      msb_r  <= 1'b1;
      half_r <= TICK_W'(1);
      sel_r  <= TICK_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_SPI_MODE:   mode_r <= cfg_wdata[1:0];
        REG_BIT_ORDER:  msb_r  <= cfg_wdata[0];
        REG_HALF_TICKS: half_r <= cfg_wdata;
        REG_SEL_TICKS:  sel_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Treat a zero delay as one tick
  always_comb begin
    cfg.cpol      = mode_r[1];
    cfg.cpha      = mode_r[0];
    cfg.msb_lead  = msb_r;
    cfg.half_lim  = (half_r == '0) ? TICK_W'(1) : half_r;
    cfg.sel_lim   = (sel_r == '0) ? TICK_W'(1) : sel_r;
  end

endmodule

@@ rtl/spi4_core.sv @@
// Serial engine of the SPI master: one tick per step
module spi4_core
  import spi4_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  tick_t   tick,
  input  cfg_t    cfg,
  output result_t res
);

  `include "assert_macros.svh"

  phase_t              phase_r, phase_nxt;
  logic [BIT_CW-1:0]   bc_r, bc_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [BYTE_W-1:0]   tx_r, tx_nxt;
  logic [BYTE_W-1:0]   rx_r, rx_nxt;
  logic                last_r, last_nxt;
  logic                mosi_r, mosi_nxt;
  logic                sel_r, sel_nxt;

  logic [TICK_W:0]     tick_inc;
  logic                half_done;
  logic                sel_done;
  logic [BYTE_W-1:0]   rx_smp;
  logic [BYTE_W-1:0]   smp_bit;
  logic                ready;
  logic                rxv;
  logic [BYTE_W-1:0]   rxb;

  // State registers, advanced once per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bc_r    <= '0;
      tick_r  <= '0;
      tx_r    <= '0;
      rx_r    <= '0;
      last_r  <= 1'b0;
      mosi_r  <= 1'b0;
      sel_r   <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      tick_r  <= tick_nxt;
      tx_r    <= tx_nxt;
      rx_r    <= rx_nxt;
      last_r  <= last_nxt;
      mosi_r  <= mosi_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Delay compares and the MISO sample for the current bit
  always_comb begin
    tick_inc  = {1'b0, tick_r} + (TICK_W+1)'(1);
    half_done = tick_inc >= {1'b0, cfg.half_lim};
    sel_done  = tick_inc >= {1'b0, cfg.sel_lim};
    smp_bit   = BYTE_W'(tick.miso) << bit_idx(cfg.msb_lead, bc_r);
    rx_smp    = rx_r | smp_bit;
  end

  // Next state and result for this tick
  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    tick_nxt  = tick_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    last_nxt  = last_r;
    mosi_nxt  = mosi_r;
    sel_nxt   = sel_r;
    ready     = 1'b0;
    rxv       = 1'b0;
    rxb       = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (tick.tx_valid) begin
          tx_nxt    = tick.tx_byte;
          last_nxt  = tick.tx_last;
          bc_nxt    = '0;
          rx_nxt    = '0;
          tick_nxt  = '0;
          ready     = 1'b1;
          sel_nxt   = 1'b0;
          phase_nxt = PH_SETUP;
        end
      end
      PH_SETUP: begin
        if (sel_done) begin
          tick_nxt  = '0;
          mosi_nxt  = tx_r[bit_idx(cfg.msb_lead, bc_r)];
          phase_nxt = PH_LEAD;
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
      PH_LEAD: begin
        if (half_done) begin
          tick_nxt  = '0;
          if (!cfg.cpha) rx_nxt = rx_smp;
          phase_nxt = PH_TRAIL;
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
      PH_TRAIL: begin
        if (half_done) begin
          tick_nxt = '0;
          if (cfg.cpha) rx_nxt = rx_smp;
          if (bc_r != LAST_BIT) begin
            // advance to the next bit of this byte
            bc_nxt    = bc_r + BIT_CW'(1);
            mosi_nxt  = tx_r[bit_idx(cfg.msb_lead, bc_r + BIT_CW'(1))];
            phase_nxt = PH_LEAD;
          end else begin
            rxv = 1'b1;
            rxb = rx_nxt;
            if (last_r) begin
              phase_nxt = PH_HOLD;
            end else if (tick.tx_valid) begin
              // chain straight into the next byte
              tx_nxt    = tick.tx_byte;
              last_nxt  = tick.tx_last;
              bc_nxt    = '0;
              rx_nxt    = '0;
              ready     = 1'b1;
              mosi_nxt  = tick.tx_byte[bit_idx(cfg.msb_lead, '0)];
              phase_nxt = PH_LEAD;
            end else begin
              phase_nxt = PH_WAIT;
            end
          end
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
      PH_WAIT: begin
        if (tick.tx_valid) begin
          tx_nxt    = tick.tx_byte;
          last_nxt  = tick.tx_last;
          bc_nxt    = '0;
          rx_nxt    = '0;
          tick_nxt  = '0;
          ready     = 1'b1;
          mosi_nxt  = tick.tx_byte[bit_idx(cfg.msb_lead, '0)];
          phase_nxt = PH_LEAD;
        end
      end
      PH_HOLD: begin
        if (sel_done) begin
          tick_nxt  = '0;
          sel_nxt   = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
      default: begin
        tick_nxt  = '0;
        sel_nxt   = 1'b1;
        phase_nxt = PH_IDLE;
      end
    endcase

    // Clock sits at CPOL, inverted between leading and trailing edges
    res.sck       = cfg.cpol ^ (phase_nxt == PH_TRAIL);
    res.mosi      = mosi_nxt;
    res.cs_n      = sel_nxt;
    res.ready_res = ready;
    res.rx_valid  = rxv;
    res.rx_byte   = rxb;
  end

  `ASSERT_NEXT(a_cs_falls, clk, rst_n, step && phase_r == PH_IDLE && tick.tx_valid, !sel_r,
               "chip select did not fall on a byte taken from idle")
  `ASSERT_IMPL(a_rx_in_trail, clk, rst_n, step && rxv, phase_r == PH_TRAIL,
               "received byte reported outside the trailing half period")
  `ASSERT_IMPL(a_cs_idle, clk, rst_n, sel_r, phase_r == PH_IDLE,
               "chip select high while a transfer is under way")

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the four-mode SPI master: tick beats in, line-level beats out
module tb
  import spi4_pkg::*;
;

  // Longest run of cycles with no beat moving on either side before the run is abandoned
  localparam int STALL_LIMIT = 1000;

  // Tracks the serial engine tick by tick and holds the line levels it should report
  class line_scoreboard;
    phase_t            ph;
    logic [BIT_CW-1:0] nbit;
    logic [TICK_W-1:0] ticks;
    logic [7:0]        tx_sh;
    logic [7:0]        rx_sh;
    logic              last_pend;
    logic              mosi_lv;
    logic              cs_lv;
    logic [1:0]        mode;
    logic              msb;
    logic [15:0]       half_reg;
    logic [15:0]       sel_reg;
    logic              last_ready;
    int                mismatches;
    result_t           expected_lines[$];

    function new();
      ph = PH_IDLE;
      nbit = '0;
      ticks = '0;
      tx_sh = '0;
      rx_sh = '0;
      last_pend = 1'b0;
      mosi_lv = 1'b0;
      cs_lv = 1'b1;
      mode = 2'd0;
      msb = 1'b1;
      half_reg = 16'd1;
      sel_reg = 16'd1;
      last_ready = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_SPI_MODE:   mode = val[1:0];
        REG_BIT_ORDER:  msb = val[0];
        REG_HALF_TICKS: half_reg = val;
        REG_SEL_TICKS:  sel_reg = val;
        default: ;
      endcase
    endfunction

    // Advance the tick counter; a zero setting counts as one tick
    function logic delay_done(logic [15:0] reg_val);
      logic [16:0] nxt;
      logic [16:0] lim;
      lim = (reg_val == 16'd0) ? 17'd1 : {1'b0, reg_val};
      nxt = {1'b0, ticks} + 17'd1;
      if (nxt >= lim) begin
        ticks = '0;
        return 1'b1;
      end
      ticks = nxt[TICK_W-1:0];
      return 1'b0;
    endfunction

    function logic [BIT_CW-1:0] wire_pos();
      return msb ? (LAST_BIT - nbit) : nbit;
    endfunction

    function void drive_mosi();
      mosi_lv = tx_sh[wire_pos()];
    endfunction

    function void sample_miso(logic m);
      rx_sh = rx_sh | (8'(m) << wire_pos());
    endfunction

    function void load(logic [7:0] b, logic l);
      tx_sh = b;
      last_pend = l;
      nbit = '0;
      rx_sh = '0;
      ticks = '0;
    endfunction

    // Step the engine by one accepted tick beat and queue the levels it leaves
    function void note_tick(tick_t t);
      result_t r;
      logic    cpha;
      r = '0;
      cpha = mode[0];
      case (ph)
        PH_IDLE: begin
          if (t.tx_valid) begin
            load(t.tx_byte, t.tx_last);
            r.ready_res = 1'b1;
            cs_lv = 1'b0;
            ph = PH_SETUP;
          end
        end
        PH_SETUP: begin
          if (delay_done(sel_reg)) begin
            drive_mosi();
            ph = PH_LEAD;
          end
        end
        PH_LEAD: begin
          if (delay_done(half_reg)) begin
            if (!cpha) sample_miso(t.miso);
            ph = PH_TRAIL;
          end
        end
        PH_TRAIL: begin
          if (delay_done(half_reg)) begin
            if (cpha) sample_miso(t.miso);
            if (nbit < LAST_BIT) begin
              nbit = nbit + 3'd1;
              drive_mosi();
              ph = PH_LEAD;
            end else begin
              r.rx_valid = 1'b1;
              r.rx_byte = rx_sh;
              if (last_pend) begin
                ticks = '0;
                ph = PH_HOLD;
              end else if (t.tx_valid) begin
                load(t.tx_byte, t.tx_last);
                r.ready_res = 1'b1;
                drive_mosi();
                ph = PH_LEAD;
              end else begin
                ph = PH_WAIT;
              end
            end
          end
        end
        PH_WAIT: begin
          if (t.tx_valid) begin
            load(t.tx_byte, t.tx_last);
            r.ready_res = 1'b1;
            drive_mosi();
            ph = PH_LEAD;
          end
        end
        PH_HOLD: begin
          if (delay_done(sel_reg)) begin
            cs_lv = 1'b1;
            ph = PH_IDLE;
          end
        end
        default: begin
          ph = PH_IDLE;
          ticks = '0;
          cs_lv = 1'b1;
        end
      endcase
      // Clock shows CPOL, inverted only between the leading and trailing edges
      r.sck = (ph == PH_TRAIL) ? ~mode[1] : mode[1];
      r.mosi = mosi_lv;
      r.cs_n = cs_lv;
      last_ready = r.ready_res;
      expected_lines = {expected_lines, r};
    endfunction

    // Compare a result beat with the oldest queued line levels
    function void check_lines(result_t got);
      result_t want;
      if (expected_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing queued: sck %b mosi %b cs_n %b rdy %b rxv %b rx %h",
                   got.sck, got.mosi, got.cs_n, got.ready_res, got.rx_valid, got.rx_byte);
        return;
      end
      want = expected_lines.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp sck %b mosi %b cs_n %b rdy %b rxv %b rx %h / got %b %b %b %b %b %h",
                   want.sck, want.mosi, want.cs_n, want.ready_res, want.rx_valid, want.rx_byte,
                   got.sck, got.mosi, got.cs_n, got.ready_res, got.rx_valid, got.rx_byte);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;   // [7:0] tx_byte, [8] miso, [15:9] zero
  logic              in_tuser;   // [0] tx_valid
  logic              in_tlast;   // tx_last
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;  // [0] sck, [1] mosi, [2] cs_n, [3] ready_res, [11:4] rx_byte
  logic              out_tuser;  // [0] rx_valid
  logic              cfg_wr_en;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  line_scoreboard sb;
  logic [7:0]     pend_byte[$];
  logic           pend_last[$];
  bit             in_gaps;
  bit             out_gaps;
  int             out_beats;
  int             beats_seen;
  int             out_wait;
  int             idle_cycles;

  spi_master_four_mode dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Check every result beat taken at a rising edge
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.sck = out_tdata[0];
      got.mosi = out_tdata[1];
      got.cs_n = out_tdata[2];
      got.ready_res = out_tdata[3];
      got.rx_byte = out_tdata[11:4];
      got.rx_valid = out_tuser;
      sb.check_lines(got);
      out_beats++;
    end
  end

  // Hold off the result side for a drawn number of cycles after each beat when output gaps are on
  always @(negedge clk) begin
    if (out_beats != beats_seen) begin
      beats_seen = out_beats;
      out_wait = out_gaps ? $urandom_range(0, 11) : 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_wait > 0) begin
      out_tready <= 1'b0;
      out_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Abandon the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL spi_master_four_mode");
        $finish;
      end
    end
  end

  // Offer one tick beat, after a drawn gap when input gaps are on, and step the scoreboard once it is taken
  task automatic send_tick(input tick_t t);
    int gap;
    gap = in_gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= t.tx_valid;
    in_tlast <= t.tx_last;
    in_tdata <= {7'd0, t.miso, t.tx_byte};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(t);
  endtask

  // Queue a transfer of one to four bytes, the final one marked last
  task automatic queue_transfer();
    int n;
    logic [7:0] b;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      pend_byte = {pend_byte, b};
      pend_last = {pend_last, (i == n - 1)};
    end
  endtask

  // Run ticks: transfers with random content, re-offers while busy, and stray offers
  task automatic run_ticks(input int budget, input bit allow_gaps);
    int    used;
    bit    from_head;
    tick_t t;
    used = 0;
    while (used < budget || pend_byte.size() > 0) begin
      if (allow_gaps && $urandom_range(0, 63) == 0) begin
        in_gaps = $urandom_range(0, 1);
        out_gaps = $urandom_range(0, 1);
      end
      if (pend_byte.size() == 0 && used < budget && $urandom_range(0, 3) == 0)
        queue_transfer();
      t = '0;
      t.miso = $urandom_range(0, 1);
      t.tx_byte = $urandom_range(0, 255);
      t.tx_last = $urandom_range(0, 1);
      from_head = 1'b0;
      if (pend_byte.size() > 0) begin
        if ($urandom_range(0, 9) < 8) begin
          t.tx_valid = 1'b1;
          t.tx_byte = pend_byte[0];
          t.tx_last = pend_last[0];
          from_head = 1'b1;
        end
      end else if ($urandom_range(0, 11) == 0) begin
        t.tx_valid = 1'b1;
      end
      send_tick(t);
      used++;
      if (from_head && sb.last_ready) begin
        void'(pend_byte.pop_front());
        void'(pend_last.pop_front());
      end
    end
    // Close any open transfer and tick on until chip select is released
    while (sb.ph != PH_IDLE) begin
      t = '0;
      t.tx_valid = (sb.ph == PH_WAIT);
      t.tx_last = 1'b1;
      t.tx_byte = $urandom_range(0, 255);
      t.miso = $urandom_range(0, 1);
      send_tick(t);
    end
  endtask

  // Drop the input valid and wait for every queued result to arrive
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_lines.size() > 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Reprogram the block while idle, then run a stretch of ticks
  task automatic run_phase(input logic [1:0] mode, input logic msb, input logic [15:0] half,
                           input logic [15:0] sel, input int budget, input bit allow_gaps);
    settle();
    write_cfg(REG_SPI_MODE, {14'd0, mode});
    write_cfg(REG_BIT_ORDER, {15'd0, msb});
    write_cfg(REG_HALF_TICKS, half);
    write_cfg(REG_SEL_TICKS, sel);
    in_gaps = allow_gaps;
    out_gaps = allow_gaps;
    run_ticks(budget, allow_gaps);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    out_beats = 0;
    beats_seen = 0;
    out_wait = 0;
    idle_cycles = 0;
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: all-ones byte then all-zeros byte, with re-offers while busy
    pend_byte = {pend_byte, 8'hFF};
    pend_last = {pend_last, 1'b0};
    pend_byte = {pend_byte, 8'h00};
    pend_last = {pend_last, 1'b1};
    run_ticks(0, 1'b1);

    // Zero delays act as one tick; LSB first in mode 1
    pend_byte = {pend_byte, 8'h80};
    pend_last = {pend_last, 1'b0};
    pend_byte = {pend_byte, 8'h01};
    pend_last = {pend_last, 1'b1};
    run_phase(2'd1, 1'b0, 16'd0, 16'd0, 0, 1'b1);

    // Random transfers through every mode and both bit orders
    for (int p = 0; p < 8; p++)
      run_phase(2'(p % 4), 1'(p / 4), 16'($urandom_range(1, 3)), 16'($urandom_range(0, 3)),
                50, p != 3);

    // Long chip-select delay, one byte, no idling
    pend_byte = {pend_byte, 8'($urandom_range(0, 255))};
    pend_last = {pend_last, 1'b1};
    run_phase(2'd3, 1'b0, 16'd1, 16'd40, 0, 1'b0);

    // Slow clock, one byte, no idling
    pend_byte = {pend_byte, 8'($urandom_range(0, 255))};
    pend_last = {pend_last, 1'b1};
    run_phase(2'd2, 1'b1, 16'd9, 16'd5, 0, 1'b0);

    run_phase(2'd1, 1'b1, 16'd2, 16'd2, 50, 1'b1);

    settle();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_lines.size() == 0) begin
      $display("PASS spi_master_four_mode");
    end else begin
      $display("FAIL spi_master_four_mode");
    end
    $finish;
  end

endmodule
